/* src/wmss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_pkg: shared types and constants for the word matrix strip mapper
// Defines the row and LED beat structs, the queue entry, the colour triple,
// the register indexes and the fixed geometry of a row word.
// ----------------------------------------------------------------------------
package wmss_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_RED        = 2'd1;
    localparam logic [1:0] CFG_GREEN      = 2'd2;
    localparam logic [1:0] CFG_BLUE       = 2'd3;

    // row word geometry
    localparam int COL_COUNT    = 11;   // column bits 5..15
    localparam int COL_FIRST    = 5;
    localparam int COL_SPAN     = 10;   // columns per row minus one
    localparam int SLOT_COUNT   = COL_COUNT + 1;   // columns plus corner
    localparam int SLOT_W       = 4;
    localparam int CORNER_ROWS  = 4;
    localparam logic [4:0] CORNER_MASK = 5'h1F;

    // reset values of the configuration registers
    localparam logic [6:0] BRIGHT_RST = 7'd50;
    localparam logic [7:0] RED_RST    = 8'd250;
    localparam logic [7:0] GREEN_RST  = 8'd255;
    localparam logic [7:0] BLUE_RST   = 8'd200;

    // divide by 100 as multiply by ceil(2^22 / 100), exact below 43690
    localparam int          DIV100_SHIFT = 22;
    localparam logic [16:0] DIV100_MUL   = 17'd41944;
    localparam int          PROD_W       = 15;

    typedef struct packed {
        logic [3:0]  row_number;
        logic [15:0] row_bits;
    } row_beat_t;

    typedef struct packed {
        logic [7:0] strip_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       lit;
        logic       last;
    } led_beat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // one classified row waiting for the emitter
    typedef struct packed {
        logic                 corner;
        logic [COL_COUNT-1:0] cols;
        logic                 odd;
        logic [7:0]           row_base;
        logic [7:0]           corner_idx;
    } row_entry_t;

endpackage

/* src/wmss_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_front: row classifier
// Turns a row beat into a queue entry: the lit column mask, the corner flag,
// the strip position of the row start and of its corner LED.
// ----------------------------------------------------------------------------
module wmss_front
    import wmss_pkg::*;
#(
    parameter int SKIP_FACTOR = 2,
    parameter int ROW_COUNT   = 10
)
(
    input  row_beat_t  row_data,
    output row_entry_t entry
);

    localparam int ROW_STEP  = COL_SPAN * SKIP_FACTOR + 1;
    localparam int STRIP_LEN = ROW_COUNT * ROW_STEP + 4;

    logic in_range;
    logic corner_hit;

    // column bits count only for rows that exist
    assign in_range   = {1'b0, row_data.row_number} < 5'(ROW_COUNT);
    assign corner_hit = (row_data.row_number < 4'(CORNER_ROWS))
                        && (row_data.row_bits[4:0] == CORNER_MASK);

    always_comb
    begin
        entry.corner   = corner_hit;
        entry.cols     = in_range ? row_data.row_bits[15:COL_FIRST] : '0;
        entry.odd      = row_data.row_number[0];
        entry.row_base = 8'(int'(row_data.row_number) * ROW_STEP);
        // corner LEDs sit past the last row, in wiring order
        case (row_data.row_number[1:0])
            2'd0:    entry.corner_idx = 8'(STRIP_LEN - 2);
            2'd1:    entry.corner_idx = 8'(STRIP_LEN - 3);
            2'd2:    entry.corner_idx = 8'(STRIP_LEN - 4);
            default: entry.corner_idx = 8'(STRIP_LEN - 1);
        endcase
    end

endmodule

/* src/wmss_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_queue: entry queue between classifier and emitter
// Small register FIFO; the head is visible combinationally to the emitter.
// ----------------------------------------------------------------------------
module wmss_queue
    import wmss_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  row_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output row_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    row_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/wmss_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_color: colour registers and brightness scaling
// Holds the four registers and keeps base * brightness / 100, saturated,
// for each channel. Products are taken at the write, the divide in the cycle after.
// ----------------------------------------------------------------------------
module wmss_color
    import wmss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output color_t     scaled
);

    logic [6:0]        bright_reg, bright_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;
    logic [PROD_W-1:0] red_prod_reg, red_prod_next;
    logic [PROD_W-1:0] green_prod_reg, green_prod_next;
    logic [PROD_W-1:0] blue_prod_reg, blue_prod_next;
    color_t            scaled_reg, scaled_next;

    // divide by 100 through the reciprocal, then clip to 8 bits
    function automatic logic [7:0] div100_sat(input logic [PROD_W-1:0] prod);
        logic [PROD_W+16:0] wide;
        logic [8:0]         quot;
        wide = prod * DIV100_MUL;
        quot = wide[DIV100_SHIFT +: 9];
        return (quot > 9'd255) ? 8'hFF : quot[7:0];
    endfunction

    // register writes
    always_comb
    begin
        bright_next = bright_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS: bright_next = cfg_data[6:0];
                CFG_RED:        red_next    = cfg_data;
                CFG_GREEN:      green_next  = cfg_data;
                CFG_BLUE:       blue_next   = cfg_data;
                default:        bright_next = bright_reg;
            endcase
        end
    end

    // one multiplier per channel, fed with the values being written
    assign red_prod_next   = red_next * bright_next;
    assign green_prod_next = green_next * bright_next;
    assign blue_prod_next  = blue_next * bright_next;

    assign scaled_next.red   = div100_sat(red_prod_reg);
    assign scaled_next.green = div100_sat(green_prod_reg);
    assign scaled_next.blue  = div100_sat(blue_prod_reg);

    assign scaled = scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg       <= BRIGHT_RST;
            red_reg          <= RED_RST;
            green_reg        <= GREEN_RST;
            blue_reg         <= BLUE_RST;
            red_prod_reg     <= PROD_W'(int'(RED_RST) * int'(BRIGHT_RST));
            green_prod_reg   <= PROD_W'(int'(GREEN_RST) * int'(BRIGHT_RST));
            blue_prod_reg    <= PROD_W'(int'(BLUE_RST) * int'(BRIGHT_RST));
            scaled_reg.red   <= 8'(int'(RED_RST) * int'(BRIGHT_RST) / 100);
            scaled_reg.green <= 8'(int'(GREEN_RST) * int'(BRIGHT_RST) / 100);
            scaled_reg.blue  <= 8'(int'(BLUE_RST) * int'(BRIGHT_RST) / 100);
        end
        else
        begin
            bright_reg     <= bright_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            red_prod_reg   <= red_prod_next;
            green_prod_reg <= green_prod_next;
            blue_prod_reg  <= blue_prod_next;
            scaled_reg     <= scaled_next;
        end
    end

endmodule

/* src/wmss_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmss_back: LED emitter
// Walks the lit columns of the head entry from bit 5 upward, then the corner,
// one beat per cycle unless stalled, into the output register, and pops the
// entry on its last beat. An entry with nothing lit gives one unlit beat.
// ----------------------------------------------------------------------------
module wmss_back
    import wmss_pkg::*;
#(
    parameter int SKIP_FACTOR = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  row_entry_t head,
    output logic       pop,
    input  color_t     scaled,
    output logic       led_valid,
    input  logic       led_stall,
    output led_beat_t  led_data
);

    logic [SLOT_COUNT-1:0] done_reg, done_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            idx_reg, idx_next;
    logic                  lit_reg, lit_next;
    logic                  last_reg, last_next;

    logic [SLOT_COUNT-1:0] req;
    logic [SLOT_COUNT-1:0] pick;
    logic [SLOT_W-1:0]     slot;
    logic                  load;
    logic                  is_last;
    logic [7:0]            col_off;

    // slots still to emit, lowest first
    assign req     = {head.corner, head.cols} & ~done_reg;
    assign pick    = req & (~req + 1'b1);
    assign is_last = ((req & (req - 1'b1)) == '0);
    assign load    = head_valid && (!valid_reg || !led_stall);
    assign pop     = load && is_last;

    // encode the picked slot
    always_comb
    begin
        slot = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (pick[k])
            begin
                slot = slot | SLOT_W'(k);
            end
        end
    end

    // odd rows run the other way along the strip
    assign col_off = head.odd ? 8'(int'(slot) * SKIP_FACTOR)
                              : 8'((COL_SPAN - int'(slot)) * SKIP_FACTOR);

    // output register
    always_comb
    begin
        valid_next = valid_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        lit_next   = lit_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            lit_next   = (req != '0);
            last_next  = is_last;
            if (req == '0)
            begin
                idx_next = '0;
            end
            else if (slot == SLOT_W'(COL_COUNT))
            begin
                idx_next = head.corner_idx;
            end
            else
            begin
                idx_next = head.row_base + col_off;
            end
            done_next = is_last ? '0 : (done_reg | pick);
        end
        else if (!led_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        lit_reg  <= lit_next;
        last_reg <= last_next;
    end

    // colours come straight from the scaled registers
    assign led_valid             = valid_reg;
    assign led_data.strip_index  = idx_reg;
    assign led_data.red_out      = lit_reg ? scaled.red : '0;
    assign led_data.green_out    = lit_reg ? scaled.green : '0;
    assign led_data.blue_out     = lit_reg ? scaled.blue : '0;
    assign led_data.lit          = lit_reg;
    assign led_data.last         = last_reg;

endmodule

/* src/word_matrix_to_serpentine_strip_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_matrix_to_serpentine_strip_top: screen row to LED strip mapper
// Maps one 16-bit row word of a word-clock screen onto positions of a
// serpentine LED strip, with the brightness scaled display colour.
// ----------------------------------------------------------------------------
// row channel: row_valid / row_stall / row_data carry one row per beat.
// led channel: led_valid / led_stall / led_data carry one LED per beat;
//   a row gives one beat per lit column (bit 5 first), then its corner LED,
//   or a single unlit beat; last marks the final beat of the row.
// config port: cfg_we writes cfg_data into register cfg_index
//   (0 brightness, 1 red, 2 green, 3 blue); write only while idle.
// path: a row beat is stored in the queue, then its first LED beat in the output register.
// throughput: one LED beat per cycle from the emitter unless led_stall holds it;
//   a row gives max(1, lit columns + corner) beats, at most 12; a new row is taken
//   every cycle while the four-entry queue has room.
// reset: registers return to brightness 50, colour 250/255/200; the queue
//   and the output register are emptied.
// stall: a stalled LED beat holds; the queue keeps taking rows until full,
//   then row_stall rises.
// ----------------------------------------------------------------------------
module word_matrix_to_serpentine_strip_top
    import wmss_pkg::*;
#(
    parameter int SKIP_FACTOR = 2,
    parameter int ROW_COUNT   = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       row_valid,
    output logic       row_stall,
    input  row_beat_t  row_data,
    output logic       led_valid,
    input  logic       led_stall,
    output led_beat_t  led_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int QUEUE_DEPTH = 4;

    row_entry_t new_entry;
    row_entry_t head;
    logic       head_valid;
    logic       pop;
    logic       full;
    color_t     scaled;

    assign row_stall = full;

    // classify incoming rows
    wmss_front #(
        .SKIP_FACTOR (SKIP_FACTOR),
        .ROW_COUNT   (ROW_COUNT)
    ) u_front (
        .row_data (row_data),
        .entry    (new_entry)
    );

    // decouple classifier and emitter
    wmss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (row_valid && !full),
        .push_entry (new_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    // colour registers and scaling
    wmss_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scaled    (scaled)
    );

    // emit LED beats
    wmss_back #(
        .SKIP_FACTOR (SKIP_FACTOR)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .scaled     (scaled),
        .led_valid  (led_valid),
        .led_stall  (led_stall),
        .led_data   (led_data)
    );

endmodule
